/* sv/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg: shared types for the first-fit block allocator
// Operation and status codes, register indexes, beat and table entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  typedef enum logic [1:0] {
    OP_MALLOC  = 2'd0,
    OP_CALLOC  = 2'd1,
    OP_FREE    = 2'd2,
    OP_REALLOC = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_UNKNOWN    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_MAX_REQUEST  = 2'd0,
    CFG_HEADER_BYTES = 2'd1,
    CFG_HEAP_BASE    = 2'd2,
    CFG_HEAP_LIMIT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_ALLOC_CHK,
    BS_SCAN,
    BS_APPEND,
    BS_FREE_OLD,
    BS_RESULT
  } back_state_e;

  localparam logic [31:0] MAX_REQUEST_RST  = 32'd100000000;
  localparam logic [7:0]  HEADER_BYTES_RST = 8'd32;
  localparam logic [47:0] HEAP_BASE_RST    = 48'd0;
  localparam logic [47:0] HEAP_LIMIT_RST   = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] size;
    logic [31:0] count;
    logic [47:0] block_addr;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] result_addr;
    logic [8:0]  free_blocks_now;
    logic [47:0] free_bytes_now;
    logic [8:0]  blocks_total;
    logic [47:0] bytes_total;
    logic [47:0] header_bytes_total;
  } out_t;

  // classified command passed from front to back
  typedef struct packed {
    op_e         op;
    logic [63:0] req;
    logic [31:0] size;
    logic [47:0] baddr;
  } cmd_t;

  // one row of the block table
  typedef struct packed {
    logic [47:0] start;
    logic [31:0] size;
    logic        free;
  } entry_t;

endpackage

`default_nettype wire

/* sv/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/ffba_queue.sv */
// ----------------------------------------------------------------------------
// ffba_queue: two-entry command queue
// Decouples the front classifier from the back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  ffba_pkg::cmd_t     data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output ffba_pkg::cmd_t     data_o
);
  import ffba_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/ffba_front.sv */
// ----------------------------------------------------------------------------
// ffba_front: input stage and classifier
// Takes request beats, forms the request size (exact calloc product) and
// hands a command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  ffba_pkg::in_t      in_data_i,
  output logic               push_o,
  output ffba_pkg::cmd_t     cmd_o,
  input  wire logic          full_i
);
  import ffba_pkg::*;

  logic        stg_valid_q, stg_valid_d;
  cmd_t        stg_q, stg_d;
  logic [63:0] prod;
  logic        take;

  assign push_o     = stg_valid_q && !full_i;
  assign in_ready_o = !stg_valid_q || !full_i;
  assign take       = in_valid_i && in_ready_o;
  assign cmd_o      = stg_q;

  // classify and size the request
  always_comb begin
    prod        = in_data_i.count * in_data_i.size;
    stg_d.op    = op_e'(in_data_i.op);
    stg_d.size  = in_data_i.size;
    stg_d.baddr = in_data_i.block_addr;
    if (op_e'(in_data_i.op) == OP_CALLOC) begin
      stg_d.req = prod;
    end else begin
      stg_d.req = {32'd0, in_data_i.size};
    end
    stg_valid_d = take || (stg_valid_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stg_q <= stg_d;
    end
  end

endmodule

`default_nettype wire

/* sv/ffba_back.sv */
// ----------------------------------------------------------------------------
// ffba_back: table sequencer
// Walks the block table for first fit or address lookup, appends blocks at
// the break, keeps tallies and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_back #(
  parameter int MaxBlocks = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [47:0]   cfg_data_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  input  ffba_pkg::cmd_t     cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ffba_pkg::out_t     out_data_o
);
  import ffba_pkg::*;

  localparam int IW = $clog2(MaxBlocks);
  localparam int CW = $clog2(MaxBlocks + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxBlocks);

  // configuration
  logic [31:0] max_req_q;
  logic [7:0]  hdr_q;
  logic [47:0] limit_q;

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic        lookup_q, lookup_d;
  logic        grow_q, grow_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic        chk_valid_q, chk_valid_d;
  logic [IW-1:0] chk_idx_q, chk_idx_d;
  logic [IW-1:0] e_idx_q, e_idx_d;
  entry_t      e_ent_q, e_ent_d;
  status_e     status_q, status_d;
  logic [47:0] addr_q, addr_d;

  logic [CW-1:0] count_q, count_d;
  logic [47:0]   break_q, break_d;
  logic [CW-1:0] free_blk_q, free_blk_d;
  logic [47:0]   free_byt_q, free_byt_d;
  logic [CW-1:0] carved_blk_q, carved_blk_d;
  logic [47:0]   carved_byt_q, carved_byt_d;

  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;
  logic          out_load;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  logic [47:0]      rd_payload;
  logic             hit;
  logic [49:0]      nb;
  logic [8+CW-1:0]  hprod;

  ffba_ram #(
    .Width ($bits(entry_t)),
    .Depth (MaxBlocks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // match on the entry read last cycle
  always_comb begin
    rd_payload = ram_rdata.start + {40'd0, hdr_q};
    if (lookup_q) begin
      hit = chk_valid_q && (rd_payload == cmd_q.baddr);
    end else begin
      hit = chk_valid_q && ram_rdata.free && ({32'd0, ram_rdata.size} >= cmd_q.req);
    end
    nb    = {2'b00, break_q} + {42'd0, hdr_q} + {18'd0, cmd_q.req[31:0]};
    hprod = {{CW{1'b0}}, hdr_q} * {8'd0, carved_blk_q};
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    lookup_d     = lookup_q;
    grow_d       = grow_q;
    rd_idx_d     = rd_idx_q;
    chk_valid_d  = 1'b0;
    chk_idx_d    = chk_idx_q;
    e_idx_d      = e_idx_q;
    e_ent_d      = e_ent_q;
    status_d     = status_q;
    addr_d       = addr_q;
    count_d      = count_q;
    break_d      = break_q;
    free_blk_d   = free_blk_q;
    free_byt_d   = free_byt_q;
    carved_blk_d = carved_blk_q;
    carved_byt_d = carved_byt_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_q;
    ram_wdata    = ram_rdata;
    cmd_pop_o    = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          status_d  = ST_OK;
          addr_d    = 48'd0;
          grow_d    = 1'b0;
          rd_idx_d  = '0;
          case (cmd_i.op)
            OP_MALLOC, OP_CALLOC: begin
              state_d = BS_ALLOC_CHK;
            end
            default: begin
              if (cmd_i.baddr == 48'd0) begin
                state_d = (cmd_i.op == OP_FREE) ? BS_RESULT : BS_ALLOC_CHK;
              end else begin
                lookup_d = 1'b1;
                state_d  = BS_SCAN;
              end
            end
          endcase
        end
      end

      BS_ALLOC_CHK: begin
        rd_idx_d = '0;
        lookup_d = 1'b0;
        if (cmd_q.req == 64'd0 || cmd_q.req > {32'd0, max_req_q}) begin
          status_d = ST_BAD_SIZE;
          state_d  = BS_RESULT;
        end else begin
          state_d = BS_SCAN;
        end
      end

      BS_SCAN: begin
        if (hit) begin
          if (!lookup_q) begin
            // first fit found: take it
            ram_we          = 1'b1;
            ram_waddr       = chk_idx_q;
            ram_wdata.free  = 1'b0;
            free_blk_d      = free_blk_q - CW'(1);
            free_byt_d      = free_byt_q - {16'd0, ram_rdata.size};
            addr_d          = rd_payload;
            state_d         = grow_q ? BS_FREE_OLD : BS_RESULT;
          end else begin
            e_idx_d = chk_idx_q;
            e_ent_d = ram_rdata;
            if (cmd_q.op == OP_FREE) begin
              if (!ram_rdata.free) begin
                ram_we         = 1'b1;
                ram_waddr      = chk_idx_q;
                ram_wdata.free = 1'b1;
                free_blk_d     = free_blk_q + CW'(1);
                free_byt_d     = free_byt_q + {16'd0, ram_rdata.size};
              end
              state_d = BS_RESULT;
            end else if ({32'd0, ram_rdata.size} >= cmd_q.req) begin
              addr_d  = cmd_q.baddr;
              state_d = BS_RESULT;
            end else begin
              grow_d  = 1'b1;
              state_d = BS_ALLOC_CHK;
            end
          end
        end else if (rd_idx_q < count_q) begin
          chk_valid_d = 1'b1;
          chk_idx_d   = rd_idx_q[IW-1:0];
          rd_idx_d    = rd_idx_q + CW'(1);
        end else if (lookup_q) begin
          status_d = ST_UNKNOWN;
          state_d  = BS_RESULT;
        end else begin
          state_d = BS_APPEND;
        end
      end

      BS_APPEND: begin
        if (nb > {2'b00, limit_q}) begin
          status_d = ST_EXHAUSTED;
          state_d  = BS_RESULT;
        end else if (count_q >= MaxCnt) begin
          status_d = ST_TABLE_FULL;
          state_d  = BS_RESULT;
        end else begin
          // carve a new block at the break
          ram_we          = 1'b1;
          ram_waddr       = count_q[IW-1:0];
          ram_wdata.start = break_q;
          ram_wdata.size  = cmd_q.req[31:0];
          ram_wdata.free  = 1'b0;
          count_d         = count_q + CW'(1);
          addr_d          = break_q + {40'd0, hdr_q};
          break_d         = nb[47:0];
          carved_blk_d    = carved_blk_q + CW'(1);
          carved_byt_d    = carved_byt_q + {16'd0, cmd_q.req[31:0]};
          state_d         = grow_q ? BS_FREE_OLD : BS_RESULT;
        end
      end

      BS_FREE_OLD: begin
        // release the block a growing realloc moved away from
        if (!e_ent_q.free) begin
          ram_we         = 1'b1;
          ram_waddr      = e_idx_q;
          ram_wdata      = e_ent_q;
          ram_wdata.free = 1'b1;
          free_blk_d     = free_blk_q + CW'(1);
          free_byt_d     = free_byt_q + {16'd0, e_ent_q.size};
        end
        state_d = BS_RESULT;
      end

      BS_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = BS_IDLE;
        end
      end

      default: begin
        state_d = BS_IDLE;
      end
    endcase

    // heap base write moves the break while the table is empty
    if (cfg_we_i && cfg_idx_e'(cfg_idx_i) == CFG_HEAP_BASE && count_q == '0) begin
      break_d = cfg_data_i;
    end
  end

  // result beat
  always_comb begin
    out_d.status             = status_q;
    out_d.result_addr        = addr_q;
    out_d.free_blocks_now    = 9'(free_blk_q);
    out_d.free_bytes_now     = free_byt_q;
    out_d.blocks_total       = 9'(carved_blk_q);
    out_d.bytes_total        = carved_byt_q;
    out_d.header_bytes_total = 48'(hprod);
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BS_IDLE;
      lookup_q     <= 1'b0;
      grow_q       <= 1'b0;
      rd_idx_q     <= '0;
      chk_valid_q  <= 1'b0;
      count_q      <= '0;
      break_q      <= HEAP_BASE_RST;
      free_blk_q   <= '0;
      free_byt_q   <= '0;
      carved_blk_q <= '0;
      carved_byt_q <= '0;
      out_valid_q  <= 1'b0;
      max_req_q    <= MAX_REQUEST_RST;
      hdr_q        <= HEADER_BYTES_RST;
      limit_q      <= HEAP_LIMIT_RST;
    end else begin
      state_q      <= state_d;
      lookup_q     <= lookup_d;
      grow_q       <= grow_d;
      rd_idx_q     <= rd_idx_d;
      chk_valid_q  <= chk_valid_d;
      count_q      <= count_d;
      break_q      <= break_d;
      free_blk_q   <= free_blk_d;
      free_byt_q   <= free_byt_d;
      carved_blk_q <= carved_blk_d;
      carved_byt_q <= carved_byt_d;
      out_valid_q  <= out_valid_d;
      // register writes; heap base only acts on the break
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_REQUEST:  max_req_q <= cfg_data_i[31:0];
          CFG_HEADER_BYTES: hdr_q     <= cfg_data_i[7:0];
          CFG_HEAP_LIMIT:   limit_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    chk_idx_q <= chk_idx_d;
    e_idx_q   <= e_idx_d;
    e_ent_q   <= e_ent_d;
    status_q  <= status_d;
    addr_q    <= addr_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

/* sv/first_fit_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core: first-fit heap bookkeeping engine
// Request beats (malloc, calloc, free, realloc) in on in_*, one result beat
// per request out on out_*. The user must write the registers on cfg_*
// only while idle; the block itself does not enforce this.
// A front stage forms the request size (calloc product in one multiply)
// and queues a command; the back sequencer reads the block table one entry
// per cycle from a registered-read RAM. A malloc on an empty table goes
// through the front stage, the queue, the size check and an empty walk to
// the append step before its result is loaded; a growing realloc walks
// twice (lookup then first-fit).
// The table walk sets the rate; the front accepts up to three further beats
// while the back is busy.
// The result sits in an output register until taken; a stalled receiver
// holds the back in its result step and the queue then fills up.
// Reset clears counts, tallies and the break (to heap base reset value);
// table rows need no clearing, as only rows below the block count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [47:0]   cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  ffba_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ffba_pkg::out_t     out_data_o
);
  import ffba_pkg::*;

  logic push, full, q_valid, pop;
  cmd_t front_cmd, q_cmd;

  ffba_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (front_cmd),
    .full_i     (full)
  );

  ffba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  ffba_back #(
    .MaxBlocks (MAX_BLOCKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (pop),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/ffba_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffba_checker: scoreboard for the first-fit block allocator
// Watches the register port and both beat channels, keeps its own copy of
// the block table, break and tallies, predicts one result per request beat
// and compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ffba_checker
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          accepted_o
);

  // register copies
  logic [31:0] max_req;
  logic [7:0]  hdr_bytes;
  logic [47:0] base_addr;
  logic [47:0] limit_addr;

  // block table and tallies
  logic [47:0] blk_start [MAX_BLOCKS];
  logic [31:0] blk_size  [MAX_BLOCKS];
  bit          blk_free  [MAX_BLOCKS];
  int          blk_used;
  logic [47:0] brk_addr;
  logic [8:0]  free_blk_cnt;
  logic [47:0] free_byte_cnt;
  logic [8:0]  carved_blk_cnt;
  logic [47:0] carved_byte_cnt;

  out_t results_due[$];
  out_t oldest;
  int   mismatches;
  int   beats_in;

  // first fit reuse, else carve at the break
  function automatic status_e carve_block(input logic [63:0] req, output logic [47:0] addr);
    logic [63:0] new_brk;
    addr = '0;
    if (req == 64'd0 || req > {32'd0, max_req}) return ST_BAD_SIZE;
    for (int i = 0; i < blk_used; i++) begin
      if (blk_free[i] && {32'd0, blk_size[i]} >= req) begin
        blk_free[i]   = 1'b0;
        free_blk_cnt  = free_blk_cnt - 9'd1;
        free_byte_cnt = free_byte_cnt - 48'(blk_size[i]);
        addr          = blk_start[i] + 48'(hdr_bytes);
        return ST_OK;
      end
    end
    new_brk = {16'd0, brk_addr} + 64'(hdr_bytes) + req;
    if (new_brk > {16'd0, limit_addr}) return ST_EXHAUSTED;
    if (blk_used >= MAX_BLOCKS) return ST_TABLE_FULL;
    blk_start[blk_used] = brk_addr;
    blk_size[blk_used]  = req[31:0];
    blk_free[blk_used]  = 1'b0;
    blk_used++;
    addr            = brk_addr + 48'(hdr_bytes);
    brk_addr        = new_brk[47:0];
    carved_blk_cnt  = carved_blk_cnt + 9'd1;
    carved_byte_cnt = carved_byte_cnt + req[47:0];
    return ST_OK;
  endfunction

  function automatic int owner_of(input logic [47:0] a);
    for (int i = 0; i < blk_used; i++)
      if (blk_start[i] + 48'(hdr_bytes) == a) return i;
    return -1;
  endfunction

  function automatic void release_block(input int i);
    if (blk_free[i]) return;
    blk_free[i]   = 1'b1;
    free_blk_cnt  = free_blk_cnt + 9'd1;
    free_byte_cnt = free_byte_cnt + 48'(blk_size[i]);
  endfunction

  function automatic out_t heap_result(input in_t req);
    out_t        r;
    status_e     st;
    logic [47:0] addr;
    int          e;
    st   = ST_OK;
    addr = '0;
    case (op_e'(req.op))
      OP_MALLOC: st = carve_block(64'(req.size), addr);
      OP_CALLOC: st = carve_block(64'(req.count) * 64'(req.size), addr);
      OP_FREE: begin
        if (req.block_addr != '0) begin
          e = owner_of(req.block_addr);
          if (e < 0) st = ST_UNKNOWN;
          else release_block(e);
        end
      end
      default: begin
        if (req.block_addr == '0) begin
          st = carve_block(64'(req.size), addr);
        end else begin
          e = owner_of(req.block_addr);
          if (e < 0) begin
            st = ST_UNKNOWN;
          end else if (blk_size[e] >= req.size) begin
            addr = req.block_addr;
          end else begin
            st = carve_block(64'(req.size), addr);
            if (st == ST_OK) release_block(e);
          end
        end
      end
    endcase
    r.status             = st;
    r.result_addr        = addr;
    r.free_blocks_now    = free_blk_cnt;
    r.free_bytes_now     = free_byte_cnt;
    r.blocks_total       = carved_blk_cnt;
    r.bytes_total        = carved_byte_cnt;
    r.header_bytes_total = 48'(hdr_bytes) * 48'(carved_blk_cnt);
    return r;
  endfunction

  task automatic report(input string what, input out_t e, input out_t a);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp st=%0d addr=%h fb=%0d fby=%h bt=%0d by=%h hb=%h | act st=%0d addr=%h fb=%0d fby=%h bt=%0d by=%h hb=%h",
               $realtime, what, e.status, e.result_addr, e.free_blocks_now, e.free_bytes_now,
               e.blocks_total, e.bytes_total, e.header_bytes_total, a.status, a.result_addr,
               a.free_blocks_now, a.free_bytes_now, a.blocks_total, a.bytes_total,
               a.header_bytes_total);
  endtask

  // one pass per edge: result beat, register write, request beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req         = MAX_REQUEST_RST;
      hdr_bytes       = HEADER_BYTES_RST;
      base_addr       = HEAP_BASE_RST;
      limit_addr      = HEAP_LIMIT_RST;
      blk_used        = 0;
      brk_addr        = HEAP_BASE_RST;
      free_blk_cnt    = '0;
      free_byte_cnt   = '0;
      carved_blk_cnt  = '0;
      carved_byte_cnt = '0;
      mismatches      = 0;
      beats_in        = 0;
      results_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report("unexpected result beat", '0, out_data_i);
        end else begin
          oldest = results_due.pop_front();
          if (oldest !== out_data_i) report("result mismatch", oldest, out_data_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_REQUEST:  max_req = cfg_data_i[31:0];
          CFG_HEADER_BYTES: hdr_bytes = cfg_data_i[7:0];
          CFG_HEAP_BASE: begin
            base_addr = cfg_data_i;
            if (blk_used == 0) brk_addr = base_addr;
          end
          default:          limit_addr = cfg_data_i;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        results_due.push_back(heap_result(in_data_i));
        beats_in++;
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= results_due.size();
    accepted_o   <= beats_in;
  end

endmodule

/* tb/tb_first_fit_block_allocator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_core: testbench for the allocator core
// Drives directed and random malloc, calloc, free and realloc beats over
// several register settings with random idling on both channels, a long
// receiver hold-off, and leaves checking to the scoreboard beside the core.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_core;
  import ffba_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  int          fail_count;
  int          pending;
  int          accepted;

  logic [31:0] cur_max;
  logic [47:0] addr_pool[$];
  int          hold_left;
  bit          held;

  first_fit_block_allocator_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ffba_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .accepted_o   (accepted)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // stretch with no idling on either side
  function automatic bit no_idle();
    return accepted >= 600 && accepted < 750;
  endfunction

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ready <= 1'b0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && accepted >= 300) begin
        held      = 1'b1;
        hold_left = 3000;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle() ? 1'b1 : ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // collect handed-out addresses for later free and realloc beats
  always @(posedge clk_i) begin
    if (out_valid && out_ready && out_data.status == ST_OK && out_data.result_addr != '0) begin
      if (addr_pool.size() < 64) addr_pool.push_back(out_data.result_addr);
      else addr_pool[$urandom_range(0, 63)] = out_data.result_addr;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [47:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic send(input in_t req);
    if (!no_idle()) begin
      while ($urandom_range(0, 99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic send_req(input op_e op, input logic [31:0] size, input logic [31:0] count,
                          input logic [47:0] addr);
    in_t req;
    req.op         = op;
    req.size       = size;
    req.count      = count;
    req.block_addr = addr;
    send(req);
  endtask

  // drain: no beat offered until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  function automatic in_t random_req();
    in_t req;
    int  r;
    r = $urandom_range(0, 99);
    req.op = (r < 40) ? OP_MALLOC : (r < 55) ? OP_CALLOC : (r < 80) ? OP_FREE : OP_REALLOC;
    r = $urandom_range(0, 99);
    if (r < 70)      req.size = $urandom_range(1, 256);
    else if (r < 78) req.size = '0;
    else if (r < 86) req.size = cur_max;
    else if (r < 90) req.size = cur_max + 32'd1;
    else             req.size = $urandom;
    if (req.op == OP_CALLOC && $urandom_range(0, 99) < 80) req.count = $urandom_range(0, 8);
    else req.count = $urandom;
    r = $urandom_range(0, 99);
    if (r < 55 && addr_pool.size() > 0)
      req.block_addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    else if (r < 65)
      req.block_addr = '0;
    else if (r < 75 && addr_pool.size() > 0)
      req.block_addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)] + 48'd1;
    else
      req.block_addr = 48'({$urandom, $urandom});
    return req;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send(random_req());
  endtask

  // stimulus
  initial begin
    rst_ni   <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_MAX_REQUEST;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero header on an empty table: first payload lands on address zero
    cur_max = 32'd4096;
    write_reg(CFG_MAX_REQUEST, 48'(cur_max));
    write_reg(CFG_HEADER_BYTES, 48'd0);
    write_reg(CFG_HEAP_BASE, 48'd0);
    write_reg(CFG_HEAP_LIMIT, 48'd20000);
    cfg_we <= 1'b0;
    @(posedge clk_i);

    // directed part
    send_req(OP_MALLOC, 32'd8, 32'd0, 48'd0);
    send_req(OP_FREE, 32'd0, 32'd0, 48'd0);
    send_req(OP_REALLOC, 32'd4, 32'd0, 48'd0);
    send_req(OP_MALLOC, 32'd0, 32'd0, 48'd0);
    send_req(OP_MALLOC, cur_max, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_req(OP_MALLOC, cur_max + 32'd1, 32'd0, 48'd0);
    send_req(OP_CALLOC, 32'd5, 32'd3, 48'd0);
    send_req(OP_CALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0);
    send_req(OP_CALLOC, 32'h0001_0000, 32'h0001_0000, 48'd0);
    send_req(OP_CALLOC, 32'd7, 32'd0, 48'd0);
    send_req(OP_FREE, 32'd0, 32'd0, 48'd8);
    send_req(OP_FREE, 32'd0, 32'd0, 48'd8);
    send_req(OP_FREE, 32'd0, 32'd0, 48'd9);
    send_req(OP_REALLOC, 32'd2, 32'd0, 48'd8);
    send_req(OP_REALLOC, 32'd5000, 32'd0, 48'd12);
    send_req(OP_REALLOC, 32'd4000, 32'd0, 48'd12);
    send_req(OP_REALLOC, 32'd100, 32'd0, 48'd4108);
    send_req(OP_MALLOC, 32'd10, 32'd0, 48'd0);
    repeat (4) send_req(OP_MALLOC, cur_max, 32'd0, 48'd0);
    send_req(OP_REALLOC, 32'd3, 32'd0, 48'd0);
    send_req(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_req(OP_REALLOC, 32'd1, 32'd0, 48'h8000_0000_0000);
    wait_idle();

    // small requests, open heap: fills the table
    write_reg(CFG_HEADER_BYTES, 48'd16);
    write_reg(CFG_HEAP_LIMIT, 48'hFFFF_FFFF_FFFF);
    wait_idle();
    run_random(400);
    wait_idle();

    // widest requests and largest header
    cur_max = 32'hFFFF_FFFF;
    write_reg(CFG_MAX_REQUEST, 48'(cur_max));
    write_reg(CFG_HEADER_BYTES, 48'd255);
    wait_idle();
    run_random(300);
    wait_idle();

    // smallest requests, no room left below the limit
    cur_max = 32'd1;
    write_reg(CFG_MAX_REQUEST, 48'(cur_max));
    write_reg(CFG_HEADER_BYTES, 48'd0);
    write_reg(CFG_HEAP_BASE, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_HEAP_LIMIT, 48'd0);
    wait_idle();
    run_random(150);
    wait_idle();

    // middle setting
    cur_max = 32'd64;
    write_reg(CFG_MAX_REQUEST, 48'(cur_max));
    write_reg(CFG_HEADER_BYTES, 48'd8);
    write_reg(CFG_HEAP_BASE, 48'd0);
    write_reg(CFG_HEAP_LIMIT, 48'h0000_0100_0000);
    wait_idle();
    run_random(280);
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
